### hdl/hlpc_pkg.sv
// Shared types and constants for the hall lift position controller.
package hlpc_pkg;

  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int TARGET_WIDTH    = 15;
  localparam int LIMIT_WIDTH     = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STALL_LIMIT = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEIGHT_MAX  = 1'b1;

  localparam logic [LIMIT_WIDTH-1:0]  STALL_LIMIT_RESET = 16'd1000;
  localparam logic [TARGET_WIDTH-1:0] HEIGHT_MAX_RESET  = 15'd32767;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic [1:0] PHASE_DECIDE = 2'd3;

  typedef enum logic [3:0] {
    QUAD_A0B0 = 4'b0001,
    QUAD_A0B1 = 4'b0010,
    QUAD_A1B1 = 4'b0100,
    QUAD_A1B0 = 4'b1000
  } quad_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [1:0] count_a;
    logic [1:0] count_b;
    quad_t      quad;
  } hall_state_t;

  typedef struct packed {
    logic running;
    logic direction_up;
    logic motor_on;
    logic arrived;
    logic stalled;
  } status_t;

endpackage

### hdl/hlpc_cfg_regs.sv
// Configuration registers for the stall limit and the upper end position.
module hlpc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [hlpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [hlpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output logic [hlpc_pkg::LIMIT_WIDTH-1:0]     stall_limit,
  output logic [hlpc_pkg::TARGET_WIDTH-1:0]    height_max
);
  import hlpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      stall_limit <= STALL_LIMIT_RESET;
      height_max  <= HEIGHT_MAX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STALL_LIMIT: stall_limit <= cfg_data[LIMIT_WIDTH-1:0];
        REG_HEIGHT_MAX:  height_max  <= cfg_data[TARGET_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/hlpc_core.sv
// Next-state logic for one item: target compare, debounce, quadrature and stall check.
module hlpc_core #(
  parameter int POSITION_WIDTH    = 16,
  parameter int STALL_COUNT_WIDTH = 16
) (
  input  logic                                 kind,
  input  logic [hlpc_pkg::TARGET_WIDTH-1:0]    target_height,
  input  logic                                 hall_a,
  input  logic                                 hall_b,
  input  logic [hlpc_pkg::LIMIT_WIDTH-1:0]     stall_limit,
  input  logic [hlpc_pkg::TARGET_WIDTH-1:0]    height_max,
  input  logic [hlpc_pkg::TARGET_WIDTH-1:0]    target_cur,
  input  logic signed [POSITION_WIDTH-1:0]     position_cur,
  input  logic [STALL_COUNT_WIDTH-1:0]         idle_cur,
  input  hlpc_pkg::hall_state_t                hall_cur,
  input  hlpc_pkg::status_t                    status_cur,
  output logic [hlpc_pkg::TARGET_WIDTH-1:0]    target_next,
  output logic signed [POSITION_WIDTH-1:0]     position_next,
  output logic [STALL_COUNT_WIDTH-1:0]         idle_next,
  output hlpc_pkg::hall_state_t                hall_next,
  output hlpc_pkg::status_t                    status_next
);
  import hlpc_pkg::*;

  localparam int CMP_WIDTH = ((POSITION_WIDTH > TARGET_WIDTH) ? POSITION_WIDTH
                                                              : TARGET_WIDTH) + 1;
  localparam int LIM_CMP_WIDTH = (STALL_COUNT_WIDTH > LIMIT_WIDTH) ? STALL_COUNT_WIDTH
                                                                    : LIMIT_WIDTH;

  logic signed [CMP_WIDTH-1:0] pos_ext;
  logic signed [CMP_WIDTH-1:0] tgt_ext;
  logic                        sens_a;
  logic                        sens_b;
  logic                        step_up;
  logic                        step_down;
  logic [STALL_COUNT_WIDTH-1:0] idle_inc;
  logic                        stall_hit;

  assign pos_ext = CMP_WIDTH'(position_cur);
  assign tgt_ext = signed'(CMP_WIDTH'(target_cur));
  assign sens_a  = hall_cur.count_a[1];
  assign sens_b  = hall_cur.count_b[1];
  assign idle_inc = (idle_cur == '1) ? idle_cur : idle_cur + 1'b1;
  assign stall_hit = LIM_CMP_WIDTH'(idle_inc) >= LIM_CMP_WIDTH'(stall_limit);

  always_comb begin
    target_next   = target_cur;
    position_next = position_cur;
    idle_next     = idle_cur;
    hall_next     = hall_cur;
    status_next   = status_cur;
    status_next.arrived = 1'b0;
    status_next.stalled = 1'b0;
    step_up   = 1'b0;
    step_down = 1'b0;

    if (kind == KIND_START) begin
      target_next         = target_height;
      status_next.running = 1'b1;
    end else if (status_cur.running) begin
      if (tgt_ext > pos_ext) begin
        status_next.direction_up = 1'b1;
      end else if (tgt_ext < pos_ext) begin
        status_next.direction_up = 1'b0;
      end
      if (tgt_ext == pos_ext) begin
        status_next.running  = 1'b0;
        status_next.motor_on = 1'b0;
        status_next.arrived  = 1'b1;
      end else begin
        status_next.motor_on = 1'b1;
        if (hall_cur.phase != PHASE_DECIDE) begin
          hall_next.count_a = hall_cur.count_a + 2'(hall_a);
          hall_next.count_b = hall_cur.count_b + 2'(hall_b);
          hall_next.phase   = hall_cur.phase + 2'd1;
        end else begin
          hall_next.count_a = 2'd0;
          hall_next.count_b = 2'd0;
          hall_next.phase   = 2'd0;
          case (hall_cur.quad)
            QUAD_A0B0: begin
              if (sens_b) begin
                hall_next.quad = QUAD_A0B1;
                step_up        = 1'b1;
              end else if (sens_a) begin
                hall_next.quad = QUAD_A1B0;
              end
            end
            QUAD_A0B1: begin
              if (sens_a) begin
                hall_next.quad = QUAD_A1B1;
              end else if (!sens_b) begin
                hall_next.quad = QUAD_A0B0;
                step_down      = 1'b1;
              end
            end
            QUAD_A1B1: begin
              if (!sens_b) begin
                hall_next.quad = QUAD_A1B0;
              end else if (!sens_a) begin
                hall_next.quad = QUAD_A0B1;
              end
            end
            default: begin
              if (!sens_a) begin
                hall_next.quad = QUAD_A0B0;
              end else if (sens_b) begin
                hall_next.quad = QUAD_A1B1;
              end
            end
          endcase
          if (step_up) begin
            position_next = position_cur + 1'b1;
            idle_next     = '0;
          end else if (step_down) begin
            position_next = position_cur - 1'b1;
            idle_next     = '0;
          end else begin
            idle_next = idle_inc;
            if (stall_hit) begin
              status_next.running  = 1'b0;
              status_next.motor_on = 1'b0;
              status_next.stalled  = 1'b1;
              position_next = status_next.direction_up ? POSITION_WIDTH'(height_max)
                                                       : '0;
            end
          end
        end
      end
    end
  end

endmodule

### hdl/hall_lift_position_controller.sv
// Top level of the hall lift position controller: item registers, state and result register.
// The block takes one item per clock cycle while in_stall is low. Each accepted item lands
// in an input register, its state update and result are formed by one pass of logic, and
// the result is written into the output register once the output side can advance. The
// input register keeps taking items while a finished result waits under stall; only when
// both registers are full does the input side stall. Configuration writes are always ready
// and take effect in the cycle after the write.
module hall_lift_position_controller #(
  parameter int POSITION_WIDTH    = 16,
  parameter int STALL_COUNT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic [hlpc_pkg::TARGET_WIDTH-1:0]    target_height,
  input  logic                                 hall_a,
  input  logic                                 hall_b,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [POSITION_WIDTH-1:0]     position,
  output logic                                 running,
  output logic                                 direction_up,
  output logic                                 motor_on,
  output logic                                 arrived,
  output logic                                 stalled,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hlpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [hlpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import hlpc_pkg::*;

  logic [LIMIT_WIDTH-1:0]       stall_limit;
  logic [TARGET_WIDTH-1:0]      height_max;

  logic                         in_full;
  logic                         in_kind;
  logic [TARGET_WIDTH-1:0]      in_target;
  logic                         in_a;
  logic                         in_b;

  logic [TARGET_WIDTH-1:0]      target_reg;
  logic signed [POSITION_WIDTH-1:0] position_reg;
  logic [STALL_COUNT_WIDTH-1:0] idle_rounds;
  hall_state_t                  hall_state;
  status_t                      status;

  logic [TARGET_WIDTH-1:0]      target_next;
  logic signed [POSITION_WIDTH-1:0] position_next;
  logic [STALL_COUNT_WIDTH-1:0] idle_next;
  hall_state_t                  hall_next;
  status_t                      status_next;

  logic                         advance;
  logic                         in_accept;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_full && !advance;
  assign in_accept = in_valid && !in_stall;

  hlpc_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .stall_limit (stall_limit),
    .height_max  (height_max)
  );

  hlpc_core #(
    .POSITION_WIDTH    (POSITION_WIDTH),
    .STALL_COUNT_WIDTH (STALL_COUNT_WIDTH)
  ) u_core (
    .kind          (in_kind),
    .target_height (in_target),
    .hall_a        (in_a),
    .hall_b        (in_b),
    .stall_limit   (stall_limit),
    .height_max    (height_max),
    .target_cur    (target_reg),
    .position_cur  (position_reg),
    .idle_cur      (idle_rounds),
    .hall_cur      (hall_state),
    .status_cur    (status),
    .target_next   (target_next),
    .position_next (position_next),
    .idle_next     (idle_next),
    .hall_next     (hall_next),
    .status_next   (status_next)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_kind   <= kind;
      in_target <= target_height;
      in_a      <= hall_a;
      in_b      <= hall_b;
    end
    if (in_full && advance) begin
      position     <= position_next;
      running      <= status_next.running;
      direction_up <= status_next.direction_up;
      motor_on     <= status_next.motor_on;
      arrived      <= status_next.arrived;
      stalled      <= status_next.stalled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      out_valid    <= 1'b0;
      target_reg   <= '0;
      position_reg <= '0;
      idle_rounds  <= '0;
      hall_state   <= '{phase: 2'd0, count_a: 2'd0, count_b: 2'd0, quad: QUAD_A0B0};
      status       <= '0;
    end else begin
      if (in_accept) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (in_full && advance) begin
        out_valid    <= 1'b1;
        target_reg   <= target_next;
        position_reg <= position_next;
        idle_rounds  <= idle_next;
        hall_state   <= hall_next;
        status       <= status_next;
      end else if (advance) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### verif/hall_lift_position_controller_tb.sv
// Self-checking testbench for the hall lift position controller with a predicting scoreboard.
module hall_lift_position_controller_tb;
  import hlpc_pkg::*;

  typedef struct packed {
    logic signed [15:0] position;
    status_t            flags;
  } lift_result_t;

  class lift_tracker;
    logic [15:0]        stall_rounds_limit;
    logic [14:0]        top_height;
    logic               moving;
    logic [14:0]        goal;
    logic signed [15:0] count;
    logic               heading_up;
    logic               drive;
    logic [1:0]         sample_slot;
    logic [1:0]         highs_a;
    logic [1:0]         highs_b;
    quad_t              quad;
    logic [15:0]        still_rounds;
    lift_result_t       awaited[$];
    int                 fails;

    function new();
      stall_rounds_limit = STALL_LIMIT_RESET;
      top_height = HEIGHT_MAX_RESET;
      moving = 1'b0;
      goal = '0;
      count = '0;
      heading_up = 1'b0;
      drive = 1'b0;
      sample_slot = '0;
      highs_a = '0;
      highs_b = '0;
      quad = QUAD_A0B0;
      still_rounds = '0;
      fails = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] data);
      if (idx == REG_STALL_LIMIT) begin
        stall_rounds_limit = data;
      end else if (idx == REG_HEIGHT_MAX) begin
        top_height = data[14:0];
      end
    endfunction

    // Returns 1 when this decision round declares a stall.
    function bit sense_round(logic a, logic b);
      logic               da;
      logic               db;
      logic signed [15:0] was;
      if (sample_slot != PHASE_DECIDE) begin
        highs_a = highs_a + 2'(a);
        highs_b = highs_b + 2'(b);
        sample_slot = sample_slot + 2'd1;
        return 1'b0;
      end
      da = highs_a >= 2;
      db = highs_b >= 2;
      highs_a = '0;
      highs_b = '0;
      sample_slot = '0;
      was = count;
      case (quad)
        QUAD_A0B0: begin
          if (db) begin
            quad = QUAD_A0B1;
            count = count + 16'sd1;
          end else if (da) begin
            quad = QUAD_A1B0;
          end
        end
        QUAD_A0B1: begin
          if (da) begin
            quad = QUAD_A1B1;
          end else if (!db) begin
            quad = QUAD_A0B0;
            count = count - 16'sd1;
          end
        end
        QUAD_A1B1: begin
          if (!db) quad = QUAD_A1B0;
          else if (!da) quad = QUAD_A0B1;
        end
        default: begin
          if (!da) quad = QUAD_A0B0;
          else if (db) quad = QUAD_A1B1;
        end
      endcase
      if (count == was) begin
        if (still_rounds != 16'hFFFF) still_rounds = still_rounds + 16'd1;
        return still_rounds >= stall_rounds_limit;
      end
      still_rounds = '0;
      return 1'b0;
    endfunction

    function void note_item(logic k, logic [14:0] t, logic a, logic b);
      lift_result_t e;
      int           g;
      int           p;
      logic         arr;
      logic         stl;
      arr = 1'b0;
      stl = 1'b0;
      if (k == KIND_START) begin
        goal = t;
        moving = 1'b1;
      end else if (moving) begin
        g = goal;
        p = count;
        if (g > p) heading_up = 1'b1;
        else if (g < p) heading_up = 1'b0;
        if (g == p) begin
          moving = 1'b0;
          drive = 1'b0;
          arr = 1'b1;
        end else begin
          drive = 1'b1;
          if (sense_round(a, b)) begin
            moving = 1'b0;
            drive = 1'b0;
            stl = 1'b1;
            count = heading_up ? {1'b0, top_height} : '0;
          end
        end
      end
      e.position = count;
      e.flags.running = moving;
      e.flags.direction_up = heading_up;
      e.flags.motor_on = drive;
      e.flags.arrived = arr;
      e.flags.stalled = stl;
      awaited.push_back(e);
    endfunction

    function void compare_field(string name, int exp, int got);
      if (exp != got) begin
        fails++;
        if (fails <= 10) $display("%s mismatch: expected %0d, got %0d", name, exp, got);
      end
    endfunction

    function void check_result(lift_result_t got);
      lift_result_t e;
      if (awaited.size() == 0) begin
        fails++;
        if (fails <= 10) $display("Result with no item waiting: position %0d", got.position);
        return;
      end
      e = awaited.pop_front();
      compare_field("position", e.position, got.position);
      compare_field("running", e.flags.running, got.flags.running);
      compare_field("direction_up", e.flags.direction_up, got.flags.direction_up);
      compare_field("motor_on", e.flags.motor_on, got.flags.motor_on);
      compare_field("arrived", e.flags.arrived, got.flags.arrived);
      compare_field("stalled", e.flags.stalled, got.flags.stalled);
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       kind = KIND_TICK;
  logic [TARGET_WIDTH-1:0]    target_height = '0;
  logic                       hall_a = 1'b0;
  logic                       hall_b = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [15:0]         position;
  logic                       running;
  logic                       direction_up;
  logic                       motor_on;
  logic                       arrived;
  logic                       stalled;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_STALL_LIMIT;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  lift_tracker  lift;
  lift_result_t seen;
  bit           steady = 1'b0;
  logic [1:0]   want = 2'b00;

  hall_lift_position_controller uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .target_height(target_height), .hall_a(hall_a), .hall_b(hall_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .position(position), .running(running), .direction_up(direction_up),
    .motor_on(motor_on), .arrived(arrived), .stalled(stalled),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.position = position;
        seen.flags.running = running;
        seen.flags.direction_up = direction_up;
        seen.flags.motor_on = motor_on;
        seen.flags.arrived = arrived;
        seen.flags.stalled = stalled;
        lift.check_result(seen);
      end
      out_stall <= !steady && ($urandom_range(0, 99) < 32);
    end
  end

  task automatic send_item(logic k, logic [14:0] t, logic a, logic b);
    if (!steady) begin
      while ($urandom_range(0, 99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    kind <= k;
    target_height <= t;
    hall_a <= a;
    hall_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lift.note_item(k, t, a, b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (lift.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lift.write_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [1:0] round_levels(quad_t q, int step);
    case (q)
      QUAD_A0B0: return step > 0 ? 2'b01 : step < 0 ? 2'b10 : 2'b00;
      QUAD_A0B1: return step > 0 ? 2'b11 : step < 0 ? 2'b00 : 2'b01;
      QUAD_A1B1: return step > 0 ? 2'b10 : step < 0 ? 2'b01 : 2'b11;
      default:   return step > 0 ? 2'b00 : step < 0 ? 2'b11 : 2'b10;
    endcase
  endfunction

  // Sensor levels for the next tick: near the target a round mostly moves toward it, far off it
  // more often holds still; it sometimes moves away, and each sample may be flipped by noise.
  function automatic logic [1:0] tick_levels();
    int         g;
    int         p;
    int         r;
    int         step;
    logic       up;
    logic       far_off;
    logic [1:0] lv;
    g = lift.goal;
    p = lift.count;
    if (lift.sample_slot == PHASE_DECIDE) return 2'($urandom_range(0, 3));
    if (lift.sample_slot == 2'd0) begin
      up = (g > p) ? 1'b1 : (g < p) ? 1'b0 : lift.heading_up;
      far_off = (g - p > 20) || (p - g > 20);
      r = $urandom_range(0, 99);
      if (r < (far_off ? 40 : 80)) step = up ? 1 : -1;
      else if (r < (far_off ? 90 : 92)) step = 0;
      else step = up ? -1 : 1;
      want = round_levels(lift.quad, step);
    end
    lv = want;
    if ($urandom_range(0, 9) == 0) lv[1] = ~lv[1];
    if ($urandom_range(0, 9) == 0) lv[0] = ~lv[0];
    return lv;
  endfunction

  function automatic logic [14:0] near_target();
    int v;
    v = $urandom_range(0, 12);
    v = v + lift.count - 6;
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return v[14:0];
  endfunction

  task automatic random_items(int n);
    int         done;
    int         r;
    logic [1:0] lv;
    logic [14:0] t;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (!lift.moving) begin
        if (r < 10) begin
          send_item(KIND_TICK, 15'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          t = (r < 22) ? 15'($urandom) : near_target();
          send_item(KIND_START, t, 1'($urandom), 1'($urandom));
          done++;
        end
      end else begin
        if (r < 4) begin
          send_item(KIND_START, near_target(), 1'($urandom), 1'($urandom));
        end else if (r < 10) begin
          send_item(KIND_TICK, 15'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          lv = tick_levels();
          send_item(KIND_TICK, 15'($urandom), lv[1], lv[0]);
        end
        done++;
      end
    end
  endtask

  task automatic run_phase(logic [15:0] limit, logic [15:0] top, int n);
    drain();
    cfg_write(REG_STALL_LIMIT, limit);
    cfg_write(REG_HEIGHT_MAX, top);
    random_items(n);
  endtask

  initial begin
    lift = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(KIND_TICK, 15'h7FFF, 1'b1, 1'b1);
    send_item(KIND_START, 15'h0000, 1'b0, 1'b0);
    send_item(KIND_TICK, 15'h0000, 1'b1, 1'b0);
    send_item(KIND_START, 15'h7FFF, 1'b1, 1'b1);
    repeat (3) send_item(KIND_TICK, 15'h0000, 1'b0, 1'b1);
    send_item(KIND_TICK, 15'h0000, 1'b1, 1'b0);
    send_item(KIND_START, 15'h0000, 1'b0, 1'b1);
    repeat (3) send_item(KIND_TICK, 15'h7FFF, 1'b0, 1'b0);
    send_item(KIND_TICK, 15'h0000, 1'b1, 1'b1);
    send_item(KIND_TICK, 15'h0000, 1'b0, 1'b0);
    send_item(KIND_START, 15'h0002, 1'b1, 1'b0);
    send_item(KIND_TICK, 15'h0000, 1'b1, 1'b0);
    send_item(KIND_TICK, 15'h0000, 1'b1, 1'b1);
    send_item(KIND_TICK, 15'h0000, 1'b0, 1'b1);
    send_item(KIND_TICK, 15'h0000, 1'b0, 1'b0);
    send_item(KIND_START, 15'h4000, 1'b0, 1'b0);
    random_items(100);

    run_phase(16'd1, 16'h0000, 125);
    run_phase(16'd0, 16'hFFFF, 125);
    steady = 1'b1;
    run_phase(16'hFFFF, 16'h0005, 125);
    steady = 1'b0;
    run_phase(16'd2, 16'h7FFF, 125);
    run_phase(16'd3, 16'h800C, 125);
    repeat (3) run_phase(16'($urandom_range(1, 6)), 16'($urandom), 125);

    drain();
    repeat (8) @(posedge clk);
    if (lift.fails == 0 && lift.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

### files.f
hdl/hlpc_pkg.sv
hdl/hlpc_cfg_regs.sv
hdl/hlpc_core.sv
hdl/hall_lift_position_controller.sv
verif/hall_lift_position_controller_tb.sv
